/* src/gte_pkg.sv */
`timescale 1ns / 1ps
// Shared types, fixed-point constants and elaboration-time helpers for the
// geodetic to ECEF unit. Depends on nothing; all files but gte_dly and gte_mulq import it.
package gte_pkg;

  localparam int   CORDIC_STEPS_DEF = 32;
  localparam int   NEWTON_STEPS     = 8;
  localparam int   MUL_LAT          = 2;
  localparam longint ONE_Q60        = 64'sd1 <<< 60;
  localparam longint A_MM           = 64'sd6378137000;
  localparam longint OUT_MAX        = (64'sd1 <<< 34) - 64'sd1;
  localparam longint OUT_MIN        = -(64'sd1 <<< 34);

  typedef struct packed {
    logic signed [31:0] lat;
    logic               lat_flip;
    logic signed [31:0] lon;
    logic               lon_flip;
    logic signed [31:0] alt;
  } gte_item_t;

  // Rounded signed product, shifted right by s, ties away from zero.
  function automatic longint mulq_f(input longint a, input longint b, input int s);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [143:0] p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    p   = {80'd0, ua} * {80'd0, ub};
    p   = p + (144'd1 << (s - 1));
    p   = p >> s;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // Truncating unsigned quotient by restoring long division.
  function automatic logic [63:0] udiv_f(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint atan_recip_f(input longint unsigned m);
    longint unsigned p;
    longint unsigned k;
    longint          sum;
    longint          term;
    p   = udiv_f(64'(ONE_Q60), m);
    k   = 0;
    sum = 0;
    while (p != 0) begin
      term = longint'(udiv_f(p, 2 * k + 1));
      sum  = k[0] ? sum - term : sum + term;
      p    = udiv_f(udiv_f(p, m), m);
      k    = k + 1;
    end
    return sum;
  endfunction

  function automatic longint quarter_f();
    return 4 * atan_recip_f(64'd5) - atan_recip_f(64'd239);
  endfunction

  function automatic longint atn_f(input int i);
    return (i == 0) ? quarter_f() : atan_recip_f(64'd1 << i);
  endfunction

  function automatic longint rsqrt_f(input longint v, input longint r0);
    longint r;
    longint vr2;
    r = r0;
    for (int it = 0; it < NEWTON_STEPS; it++) begin
      vr2 = mulq_f(v, mulq_f(r, r, 60), 60);
      r   = mulq_f(r, 3 * ONE_Q60 - vr2, 61);
    end
    return r;
  endfunction

  function automatic longint kinv_f(input int steps);
    longint unsigned k2;
    k2 = 64'(ONE_Q60);
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 63) k2 = k2 + (k2 >> (2 * i));
    end
    return rsqrt_f(longint'(k2), ONE_Q60 / 2 + ONE_Q60 / 8);
  endfunction

  // Flattening as a rounded binary fraction, then e2 = f(2 - f).
  function automatic longint e2_f();
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 64'd1000000000;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= 64'd298257223563) begin
        rem = rem - 64'd298257223563;
        q   = q | 64'd1;
      end
    end
    if (2 * rem >= 64'd298257223563) q = q + 1;
    return mulq_f(longint'(q), 2 * ONE_Q60 - longint'(q), 60);
  endfunction

  localparam longint PI_Q60  = 4 * quarter_f();
  localparam longint E2_Q60  = e2_f();
  localparam longint OME2_Q60 = ONE_Q60 - E2_Q60;

endpackage

/* src/geodetic_to_ecef_unit.sv */
`timescale 1ns / 1ps
// Geodetic (WGS84) to ECEF conversion unit, top level.
// Depends on gte_pkg, gte_front and gte_back.
//
// A word is taken at every clock edge with start high and busy low, so one
// position may be issued every cycle; busy stays low in normal operation
// because the front end's two-word queue is drained every cycle. Each
// result is strobed by out_valid for exactly one cycle, in issue order. Its
// path runs through the CORDIC stages, the eight Newton steps of the inverse
// square root (three two-stage multipliers each) and the final product chain.
// Results cannot be held off, so the receiver must take each one as it appears.
module geodetic_to_ecef_unit
  import gte_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [31:0] in_altitude,
  output logic               out_valid,
  output logic signed [34:0] out_ecef_x,
  output logic signed [34:0] out_ecef_y,
  output logic signed [34:0] out_ecef_z
);
  logic      q_valid;
  gte_item_t q_item;

  gte_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_latitude(in_latitude), .in_longitude(in_longitude), .in_altitude(in_altitude),
    .q_valid(q_valid), .q_item(q_item)
  );

  gte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
    .out_valid(out_valid), .out_ecef_x(out_ecef_x), .out_ecef_y(out_ecef_y),
    .out_ecef_z(out_ecef_z)
  );
endmodule

/* src/gte_dly.sv */
`timescale 1ns / 1ps
// Fixed-length delay line for payload that travels alongside the arithmetic.
// Stand-alone; no package needed.
module gte_dly #(
  parameter int W = 64,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
  end

  assign q = tap_r[D-1];
endmodule

/* src/gte_mulq.sv */
`timescale 1ns / 1ps
// Two-stage 64x64 signed multiplier with rounded right shift: four 32x32
// partial products, then summation and rounding. Uses gte_pkg nothing.
module gte_mulq #(
  parameter int SHIFT = 60
) (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);
  localparam int PW = 144;

  logic [63:0] ua;
  logic [63:0] ub;
  logic        neg_r;
  logic [63:0] p00_r;
  logic [63:0] p01_r;
  logic [63:0] p10_r;
  logic [63:0] p11_r;
  logic [PW-1:0] sum;
  logic [PW-1:0] shf;

  assign ua = a[63] ? (~a + 64'd1) : a;
  assign ub = b[63] ? (~b + 64'd1) : b;

  always_ff @(posedge clk) begin
    neg_r <= a[63] ^ b[63];
    p00_r <= ua[31:0]  * ub[31:0];
    p01_r <= ua[31:0]  * ub[63:32];
    p10_r <= ua[63:32] * ub[31:0];
    p11_r <= ua[63:32] * ub[63:32];
  end

  assign sum = {80'd0, p00_r} + ({80'd0, p01_r} << 32) + ({80'd0, p10_r} << 32)
             + ({80'd0, p11_r} << 64) + (PW'(1) << (SHIFT - 1));
  assign shf = sum >> SHIFT;

  always_ff @(posedge clk) begin
    p <= neg_r ? -$signed(shf[63:0]) : $signed(shf[63:0]);
  end
endmodule

/* src/gte_cordic.sv */
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, giving sine
// and cosine in Q60. Depends on gte_pkg for the arctangent table and gain.
module gte_cordic
  import gte_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic signed [63:0] z_in,
  input  logic               flip_in,
  output logic signed [63:0] sn,
  output logic signed [63:0] cs
);
  localparam longint KINV = kinv_f(STEPS);

  logic signed [63:0] x_r [STEPS+1];
  logic signed [63:0] y_r [STEPS+1];
  logic signed [63:0] z_r [STEPS+1];
  logic               f_r [STEPS+1];

  assign x_r[0] = KINV;
  assign y_r[0] = '0;
  assign z_r[0] = z_in;
  assign f_r[0] = flip_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam longint ATN = atn_f(i);
    always_ff @(posedge clk) begin
      if (!z_r[i][63]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATN;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATN;
      end
      f_r[i+1] <= f_r[i];
    end
  end

  // Angles folded by pi come back with both outputs negated.
  always_ff @(posedge clk) begin
    sn <= f_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
    cs <= f_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  end
endmodule

/* src/gte_rsqrt.sv */
`timescale 1ns / 1ps
// Pipelined inverse square root in Q60: fixed Newton steps from one, three
// multipliers per step. Depends on gte_pkg, gte_mulq and gte_dly.
module gte_rsqrt
  import gte_pkg::*;
(
  input  logic               clk,
  input  logic signed [63:0] v,
  output logic signed [63:0] r
);
  logic signed [63:0] v_s [NEWTON_STEPS+1];
  logic signed [63:0] r_s [NEWTON_STEPS+1];

  assign v_s[0] = v;
  assign r_s[0] = ONE_Q60;

  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
    logic signed [63:0] rr;
    logic signed [63:0] v_d;
    logic signed [63:0] vr2;
    logic signed [63:0] r_d;
    gte_mulq #(.SHIFT(60)) u_rr (.clk(clk), .a(r_s[k]), .b(r_s[k]), .p(rr));
    gte_dly #(.W(64), .D(MUL_LAT)) u_vd (.clk(clk), .d(v_s[k]), .q(v_d));
    gte_mulq #(.SHIFT(60)) u_vr (.clk(clk), .a(v_d), .b(rr), .p(vr2));
    gte_dly #(.W(64), .D(2 * MUL_LAT)) u_rd (.clk(clk), .d(r_s[k]), .q(r_d));
    gte_mulq #(.SHIFT(61)) u_rn (.clk(clk), .a(r_d), .b(3 * ONE_Q60 - vr2), .p(r_s[k+1]));
    gte_dly #(.W(64), .D(2 * MUL_LAT)) u_vn (.clk(clk), .d(v_d), .q(v_s[k+1]));
  end

  assign r = r_s[NEWTON_STEPS];
endmodule

/* src/gte_front.sv */
`timescale 1ns / 1ps
// Front end: takes a command word, folds angles into +-pi/2 and queues the
// word for the back end. Depends on gte_pkg.
module gte_front
  import gte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [31:0] in_altitude,
  output logic               q_valid,
  output gte_item_t          q_item
);
  gte_item_t   item;
  gte_item_t   q_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;

  function automatic logic far_angle(input logic signed [31:0] a);
    return (a > 32'sd1073741824) || (a < -32'sd1073741824);
  endfunction

  always_comb begin
    item.lat_flip = far_angle(in_latitude);
    item.lon_flip = far_angle(in_longitude);
    item.lat      = {in_latitude[31] ^ item.lat_flip, in_latitude[30:0]};
    item.lon      = {in_longitude[31] ^ item.lon_flip, in_longitude[30:0]};
    item.alt      = in_altitude;
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign pop     = (cnt_r != 2'd0);
  assign q_valid = pop;
  assign q_item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // A word is popped every cycle the queue is not empty, so it never holds two.
  a_never_two: assert property (@(posedge clk) disable iff (!rst_n) cnt_r < 2'd2)
    else $error("queue holds two words");
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> cnt_r == 2'd1) else $error("accepted word not queued");
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !push |=> cnt_r == 2'd0) else $error("queue not drained");
endmodule

/* src/gte_back.sv */
`timescale 1ns / 1ps
// Back end: fixed-latency pipeline from folded angles and altitude to
// saturated ECEF millimetres. Depends on gte_pkg and the arithmetic units.
module gte_back
  import gte_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  gte_item_t          q_item,
  output logic               out_valid,
  output logic signed [34:0] out_ecef_x,
  output logic signed [34:0] out_ecef_y,
  output logic signed [34:0] out_ecef_z
);
  localparam int T_CS = MUL_LAT + CORDIC_STEPS + 1;
  localparam int D_RN = 2 * MUL_LAT + 3 * MUL_LAT * NEWTON_STEPS;
  localparam int T_N  = T_CS + D_RN + MUL_LAT;
  localparam int LAT  = T_N + 2 * MUL_LAT + 1;

  gte_item_t          e_r;
  logic               vld_r;
  logic [LAT-1:0]     vld_pipe_r;
  logic signed [63:0] h_q;
  logic signed [63:0] z_lat;
  logic signed [63:0] z_lon;
  logic [1:0]         flip_d;
  logic signed [63:0] sla, cla, slo, clo;
  logic signed [63:0] sin2, u, rn, n_q, h_n, h_t, zp_m, t;
  logic signed [63:0] cla_d, sla_d, slo_d, clo_d;
  logic signed [63:0] xm, ym, zm;

  always_ff @(posedge clk) begin
    e_r <= q_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      vld_pipe_r <= '0;
    end else begin
      vld_r      <= q_valid;
      vld_pipe_r <= {vld_pipe_r[LAT-2:0], vld_r};
    end
  end

  assign h_q = {{12{e_r.alt[31]}}, e_r.alt, 20'd0};

  gte_mulq #(.SHIFT(31)) u_zla (.clk(clk), .a(64'(e_r.lat)), .b(PI_Q60), .p(z_lat));
  gte_mulq #(.SHIFT(31)) u_zlo (.clk(clk), .a(64'(e_r.lon)), .b(PI_Q60), .p(z_lon));
  gte_dly #(.W(2), .D(MUL_LAT)) u_fd (.clk(clk), .d({e_r.lat_flip, e_r.lon_flip}),
    .q(flip_d));

  gte_cordic #(.STEPS(CORDIC_STEPS)) u_cla (.clk(clk), .z_in(z_lat), .flip_in(flip_d[1]),
    .sn(sla), .cs(cla));
  gte_cordic #(.STEPS(CORDIC_STEPS)) u_clo (.clk(clk), .z_in(z_lon), .flip_in(flip_d[0]),
    .sn(slo), .cs(clo));

  gte_mulq #(.SHIFT(60)) u_s2 (.clk(clk), .a(sla), .b(sla), .p(sin2));
  gte_mulq #(.SHIFT(60)) u_e2 (.clk(clk), .a(E2_Q60), .b(sin2), .p(u));
  gte_rsqrt u_rs (.clk(clk), .v(ONE_Q60 - u), .r(rn));
  gte_mulq #(.SHIFT(40)) u_n (.clk(clk), .a(rn), .b(A_MM), .p(n_q));

  gte_dly #(.W(64), .D(T_N)) u_hn (.clk(clk), .d(h_q), .q(h_n));
  gte_dly #(.W(64), .D(MUL_LAT)) u_ht (.clk(clk), .d(h_n), .q(h_t));
  gte_dly #(.W(64), .D(D_RN + MUL_LAT)) u_cd (.clk(clk), .d(cla), .q(cla_d));
  gte_dly #(.W(64), .D(D_RN + 2 * MUL_LAT)) u_sd (.clk(clk), .d(sla), .q(sla_d));
  gte_dly #(.W(64), .D(D_RN + 2 * MUL_LAT)) u_od (.clk(clk), .d(slo), .q(slo_d));
  gte_dly #(.W(64), .D(D_RN + 2 * MUL_LAT)) u_kd (.clk(clk), .d(clo), .q(clo_d));

  gte_mulq #(.SHIFT(60)) u_zp (.clk(clk), .a(n_q), .b(OME2_Q60), .p(zp_m));
  gte_mulq #(.SHIFT(60)) u_t  (.clk(clk), .a(n_q + h_n), .b(cla_d), .p(t));

  gte_mulq #(.SHIFT(80)) u_x (.clk(clk), .a(t), .b(clo_d), .p(xm));
  gte_mulq #(.SHIFT(80)) u_y (.clk(clk), .a(t), .b(slo_d), .p(ym));
  gte_mulq #(.SHIFT(80)) u_z (.clk(clk), .a(zp_m + h_t), .b(sla_d), .p(zm));

  function automatic logic signed [34:0] sat35(input logic signed [63:0] v);
    if (v > OUT_MAX) return 35'(OUT_MAX);
    if (v < OUT_MIN) return 35'(OUT_MIN);
    return v[34:0];
  endfunction

  always_ff @(posedge clk) begin
    out_ecef_x <= sat35(xm);
    out_ecef_y <= sat35(ym);
    out_ecef_z <= sat35(zm);
  end

  assign out_valid = vld_pipe_r[LAT-1];

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(q_valid, LAT + 1)) else $error("result without a source word");
  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> ##LAT out_valid) else $error("word lost in pipeline");
endmodule
